>>> sv/ring_node_direction_router_assert.svh
// assertion macros for the ring node router
// used by ring_node_direction_router.sv, no other dependencies
`ifndef RING_NODE_DIRECTION_ROUTER_ASSERT_SVH
`define RING_NODE_DIRECTION_ROUTER_ASSERT_SVH

// same-cycle implication
`define RNDR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RNDR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/rndr_pkg.sv
// constants and codes for the ring node router
// no dependencies
package rndr_pkg;

	localparam int MAX_NODES = 16;
	localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int CNT_W = $clog2(MAX_NODES + 1);

	typedef logic [7:0] node_id_t;
	typedef logic [15:0] hop_t;
	typedef logic [IDX_W-1:0] tbl_idx_t;
	typedef logic [CNT_W-1:0] tbl_cnt_t;

	localparam logic [1:0] OP_NORMAL = 2'd0;
	localparam logic [1:0] OP_DISCOVERY = 2'd1;
	localparam logic [1:0] OP_START = 2'd2;

	localparam logic [1:0] PORT_APP = 2'd0;
	localparam logic [1:0] PORT_GATE0 = 2'd1;

	localparam logic [1:0] ACT_ABSORB = 2'd0;
	localparam logic [1:0] ACT_DELIVER = 2'd1;
	localparam logic [1:0] ACT_CW = 2'd2;
	localparam logic [1:0] ACT_CCW = 2'd3;

	localparam logic KIND_NORMAL = 1'b0;
	localparam logic KIND_DISCOVERY = 1'b1;

	localparam hop_t HOP_MAX = 16'hffff;

endpackage

>>> sv/ring_node_direction_router.sv
// ring node router: packet event decode, learned node table and direction search
// depends on rndr_pkg and ring_node_direction_router_assert.svh
//
// Usage:
// in channel (in_valid/in_ready) takes one packet event per request: opcode,
// arrival_port, destination, hop_count. out channel (out_valid/out_ready)
// gives one routing decision per request; an unused opcode gives none.
// cfg channel (cfg_valid/cfg_ready) writes own_node_id; write it only while idle.
// A request that needs no table search passes the decode state and the emit
// step into the output register; a search from the application walks the
// learned table one entry per cycle out of a memory with registered read
// data and stops at the first match or at the last filled entry.
// A new request is taken only once the current one has left the emit step.
// The result sits in an output register, so the next request is taken while
// a result waits for out_ready; a stalled receiver holds the next result in
// the emit step and then stops new requests.
// Reset clears own_node_id, the table fill count and the ring-known flag;
// table contents are never cleared, only filled entries are read.
`include "ring_node_direction_router_assert.svh"

module ring_node_direction_router (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [7:0]           cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           opcode,
	input  logic [1:0]           arrival_port,
	input  logic [7:0]           destination,
	input  logic [15:0]          hop_count,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           action,
	output logic                 packet_kind,
	output logic [7:0]           out_destination,
	output logic [15:0]          out_hop_count
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DECODE = 2'd1;
	localparam logic [1:0] ST_SEARCH = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	localparam rndr_pkg::tbl_idx_t LAST_IDX = rndr_pkg::IDX_W'(rndr_pkg::MAX_NODES - 1);
	localparam rndr_pkg::tbl_cnt_t FULL_CNT = rndr_pkg::CNT_W'(rndr_pkg::MAX_NODES);

	logic [1:0] state_q;
	rndr_pkg::node_id_t own_id_q;
	rndr_pkg::tbl_cnt_t count_q;
	rndr_pkg::tbl_idx_t head_q;
	logic ring_known_q;

	logic [1:0] op_q;
	logic [1:0] port_q;
	rndr_pkg::node_id_t dest_q;
	rndr_pkg::hop_t hops_q;

	logic [1:0] res_action_q;
	logic res_kind_q;
	rndr_pkg::node_id_t res_dest_q;
	rndr_pkg::hop_t res_hops_q;

	rndr_pkg::tbl_idx_t rd_ptr_q;
	rndr_pkg::tbl_cnt_t issue_cnt_q;
	logic rd_vld_s1;
	rndr_pkg::tbl_cnt_t cmp_idx_s1;

	logic out_valid_q;
	logic [1:0] out_action_q;
	logic out_kind_q;
	rndr_pkg::node_id_t out_dest_q;
	rndr_pkg::hop_t out_hops_q;

	// learned table, physical ring buffer, newest entry at head
	rndr_pkg::node_id_t tbl_mem [rndr_pkg::MAX_NODES];
	rndr_pkg::node_id_t rd_data_s1;
	logic tbl_we;
	rndr_pkg::tbl_idx_t tbl_waddr;
	logic tbl_re;

	rndr_pkg::tbl_idx_t head_dec;
	rndr_pkg::tbl_idx_t rd_ptr_inc;
	rndr_pkg::hop_t hops_inc;
	rndr_pkg::tbl_cnt_t half_cnt;
	rndr_pkg::tbl_cnt_t last_cnt;
	logic out_free;

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign action = out_action_q;
	assign packet_kind = out_kind_q;
	assign out_destination = out_dest_q;
	assign out_hop_count = out_hops_q;

	assign head_dec = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
	assign rd_ptr_inc = (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
	assign hops_inc = (hops_q == rndr_pkg::HOP_MAX) ? hops_q : hops_q + 1'b1;
	assign half_cnt = count_q >> 1;
	assign last_cnt = count_q - 1'b1;
	assign out_free = !out_valid_q || out_ready;

	assign tbl_we = (state_q == ST_DECODE) && (op_q == rndr_pkg::OP_DISCOVERY)
		&& (dest_q != own_id_q) && (count_q != FULL_CNT);
	assign tbl_waddr = head_dec;
	assign tbl_re = (state_q == ST_SEARCH) && (issue_cnt_q < count_q);

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[tbl_waddr] <= dest_q;
		end
		if (tbl_re) begin
			rd_data_s1 <= tbl_mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q <= opcode;
			port_q <= arrival_port;
			dest_q <= destination;
			hops_q <= hop_count;
		end
		if (tbl_re) begin
			cmp_idx_s1 <= issue_cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			own_id_q <= '0;
			count_q <= '0;
			head_q <= '0;
			ring_known_q <= 1'b0;
			res_action_q <= rndr_pkg::ACT_ABSORB;
			res_kind_q <= rndr_pkg::KIND_NORMAL;
			res_dest_q <= '0;
			res_hops_q <= '0;
			rd_ptr_q <= '0;
			issue_cnt_q <= '0;
			rd_vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			out_action_q <= rndr_pkg::ACT_ABSORB;
			out_kind_q <= rndr_pkg::KIND_NORMAL;
			out_dest_q <= '0;
			out_hops_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				own_id_q <= cfg_data;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			rd_vld_s1 <= tbl_re;
			if (tbl_re) begin
				rd_ptr_q <= rd_ptr_inc;
				issue_cnt_q <= issue_cnt_q + 1'b1;
			end
			if (tbl_we) begin
				head_q <= head_dec;
				count_q <= count_q + 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					state_q <= ST_EMIT;
					res_kind_q <= rndr_pkg::KIND_NORMAL;
					res_dest_q <= dest_q;
					res_hops_q <= hops_q;
					case (op_q)
						rndr_pkg::OP_START: begin
							res_action_q <= rndr_pkg::ACT_CW;
							res_kind_q <= rndr_pkg::KIND_DISCOVERY;
							res_dest_q <= own_id_q;
							res_hops_q <= '0;
						end
						rndr_pkg::OP_DISCOVERY: begin
							if (dest_q != own_id_q) begin
								res_action_q <= rndr_pkg::ACT_CW;
								res_kind_q <= rndr_pkg::KIND_DISCOVERY;
							end else begin
								ring_known_q <= 1'b1;
								res_action_q <= rndr_pkg::ACT_ABSORB;
								res_dest_q <= '0;
								res_hops_q <= '0;
							end
						end
						rndr_pkg::OP_NORMAL: begin
							if (dest_q == own_id_q) begin
								res_action_q <= rndr_pkg::ACT_DELIVER;
							end else begin
								res_hops_q <= hops_inc;
								if (port_q == rndr_pkg::PORT_APP) begin
									res_action_q <= rndr_pkg::ACT_CW;
									if (ring_known_q && (count_q != '0)) begin
										state_q <= ST_SEARCH;
										rd_ptr_q <= head_q;
										issue_cnt_q <= '0;
									end
								end else if (port_q == rndr_pkg::PORT_GATE0) begin
									res_action_q <= rndr_pkg::ACT_CCW;
								end else begin
									res_action_q <= rndr_pkg::ACT_CW;
								end
							end
						end
						default: begin
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_SEARCH: begin
					if (rd_vld_s1) begin
						if (rd_data_s1 == dest_q) begin
							res_action_q <= (cmp_idx_s1 < half_cnt) ?
								rndr_pkg::ACT_CW : rndr_pkg::ACT_CCW;
							state_q <= ST_EMIT;
						end else if (cmp_idx_s1 == last_cnt) begin
							res_action_q <= rndr_pkg::ACT_CW;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_action_q <= res_action_q;
						out_kind_q <= res_kind_q;
						out_dest_q <= res_dest_q;
						out_hops_q <= res_hops_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`RNDR_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= FULL_CNT,
		"table count beyond capacity")
	`RNDR_ASSERT_NOW(a_read_in_search, clk, arst_n, rd_vld_s1,
		(state_q == ST_SEARCH) || (state_q == ST_EMIT), "table read data outside search")
	`RNDR_ASSERT_NEXT(a_accept_decode, clk, arst_n, in_valid && in_ready,
		state_q == ST_DECODE, "accepted request not decoded")
	`RNDR_ASSERT_NEXT(a_ring_known_sticky, clk, arst_n, ring_known_q, ring_known_q,
		"ring known flag dropped")
	`RNDR_ASSERT_NOW(a_issue_bound, clk, arst_n, state_q == ST_SEARCH,
		issue_cnt_q <= count_q, "search walked past table fill")

endmodule

>>> dv/ring_node_direction_router_tb.sv
// self-checking testbench for ring_node_direction_router: directed and random packet events
// predicts every routing decision from its own table model; depends on rndr_pkg and the rtl
module ring_node_direction_router_tb;

	localparam logic [1:0] PORT_GATE1 = 2'd2;
	localparam logic [1:0] PORT_SPARE = 2'd3;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 320;
	localparam int CYCLE_LIMIT = 500000;

	typedef struct packed {
		logic [1:0]         op;
		logic [1:0]         port;
		rndr_pkg::node_id_t dest;
		rndr_pkg::hop_t     hops;
	} packet_req_t;

	typedef struct packed {
		logic [1:0]         act;
		logic               kind;
		rndr_pkg::node_id_t dest;
		rndr_pkg::hop_t     hops;
	} route_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [7:0] cfg_data = 8'd0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] opcode = 2'd0;
	logic [1:0] arrival_port = 2'd0;
	logic [7:0] destination = 8'd0;
	logic [15:0] hop_count = 16'd0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] action;
	logic packet_kind;
	logic [7:0] out_destination;
	logic [15:0] out_hop_count;

	rndr_pkg::node_id_t node_id = 8'd0;
	rndr_pkg::node_id_t learned_ids [rndr_pkg::MAX_NODES];
	int learned_count = 0;
	bit ring_closed = 1'b0;

	packet_req_t pending_req [$];
	route_t due_route [$];
	packet_req_t offered_req;
	rndr_pkg::node_id_t id_pool [8];

	logic steady = 1'b0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int hold_left = 0;
	int errors = 0;
	int checked = 0;
	int accepted = 0;
	int cycles = 0;
	int id_settings = 0;
	int act_seen [4] = '{0, 0, 0, 0};

	ring_node_direction_router uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.arrival_port(arrival_port),
		.destination(destination),
		.hop_count(hop_count),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.action(action),
		.packet_kind(packet_kind),
		.out_destination(out_destination),
		.out_hop_count(out_hop_count)
	);

	always #5 clk = ~clk;

	function automatic bit route_packet(input packet_req_t r, output route_t d);
		int i;
		d = '{rndr_pkg::ACT_ABSORB, rndr_pkg::KIND_NORMAL, 8'd0, 16'd0};
		if (r.op == rndr_pkg::OP_START) begin
			d = '{rndr_pkg::ACT_CW, rndr_pkg::KIND_DISCOVERY, node_id, 16'd0};
			return 1'b1;
		end
		if (r.op == rndr_pkg::OP_DISCOVERY) begin
			if (r.dest == node_id) begin
				ring_closed = 1'b1;
				return 1'b1;
			end
			if (learned_count < rndr_pkg::MAX_NODES) begin
				for (i = learned_count; i > 0; i--)
					learned_ids[i] = learned_ids[i-1];
				learned_ids[0] = r.dest;
				learned_count++;
			end
			d = '{rndr_pkg::ACT_CW, rndr_pkg::KIND_DISCOVERY, r.dest, r.hops};
			return 1'b1;
		end
		if (r.op != rndr_pkg::OP_NORMAL)
			return 1'b0;
		if (r.dest == node_id) begin
			d = '{rndr_pkg::ACT_DELIVER, rndr_pkg::KIND_NORMAL, r.dest, r.hops};
			return 1'b1;
		end
		d = '{rndr_pkg::ACT_CW, rndr_pkg::KIND_NORMAL, r.dest,
			(r.hops == rndr_pkg::HOP_MAX) ? rndr_pkg::HOP_MAX : r.hops + 16'd1};
		if (r.port == rndr_pkg::PORT_GATE0) begin
			d.act = rndr_pkg::ACT_CCW;
		end else if (r.port == rndr_pkg::PORT_APP && ring_closed) begin
			// walk from the back so the first match from the front wins
			for (i = learned_count - 1; i >= 0; i--)
				if (learned_ids[i] == r.dest)
					d.act = (i < learned_count / 2) ? rndr_pkg::ACT_CW : rndr_pkg::ACT_CCW;
		end
		return 1'b1;
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	task automatic push_req(input logic [1:0] op, input logic [1:0] port,
			input rndr_pkg::node_id_t dest, input rndr_pkg::hop_t hops);
		pending_req.push_back('{op, port, dest, hops});
	endtask

	task automatic push_random(input int n, input int disc_pct);
		int k;
		int roll;
		logic [1:0] op;
		logic [1:0] port;
		rndr_pkg::node_id_t dest;
		rndr_pkg::hop_t hops;
		for (k = 0; k < n; k++) begin
			roll = $urandom_range(99);
			if (roll < disc_pct)
				op = rndr_pkg::OP_DISCOVERY;
			else if (roll < disc_pct + 5)
				op = rndr_pkg::OP_START;
			else if (roll < disc_pct + 8)
				op = OP_UNUSED;
			else
				op = rndr_pkg::OP_NORMAL;
			roll = $urandom_range(99);
			if (op == rndr_pkg::OP_DISCOVERY)
				dest = (roll < 25) ? node_id : (roll < 75) ? id_pool[$urandom_range(7)]
					: rndr_pkg::node_id_t'($urandom);
			else
				dest = (roll < 10) ? node_id : (roll < 60) ? id_pool[$urandom_range(7)]
					: rndr_pkg::node_id_t'($urandom);
			roll = $urandom_range(99);
			hops = (roll < 10) ? rndr_pkg::HOP_MAX : (roll < 20) ? rndr_pkg::HOP_MAX - 16'd1
				: (roll < 30) ? 16'd0 : rndr_pkg::hop_t'($urandom);
			roll = $urandom_range(99);
			port = (roll < 55) ? rndr_pkg::PORT_APP : (roll < 70) ? rndr_pkg::PORT_GATE0
				: (roll < 90) ? PORT_GATE1 : PORT_SPARE;
			push_req(op, port, dest, hops);
		end
	endtask

	task automatic drain;
		while (pending_req.size() != 0 || in_valid || due_route.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_own_id(input rndr_pkg::node_id_t v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		node_id = v;
		id_settings++;
	endtask

	// sender: offers queued requests, predicts on acceptance
	always @(posedge clk) begin
		route_t d;
		if (in_valid && in_ready) begin
			accepted++;
			if (route_packet(offered_req, d))
				due_route.push_back(d);
		end
		if (!in_valid || in_ready) begin
			if (pending_req.size() != 0 && (steady || $urandom_range(99) >= 20)) begin
				offered_req = pending_req.pop_front();
				in_valid <= 1'b1;
				opcode <= offered_req.op;
				arrival_port <= offered_req.port;
				destination <= offered_req.dest;
				hop_count <= offered_req.hops;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver readiness with one long hold-off
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_left <= 300;
			hold_done <= 1'b1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= arst_n && (steady || $urandom_range(99) >= 20);
		end
	end

	always @(posedge clk) begin
		route_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_route.size() == 0) begin
				$display("%0t: unexpected decision, expected none, actual %0d/%0d/%0d/%0d",
					$time, action, packet_kind, out_destination, out_hop_count);
				errors++;
			end else begin
				want = due_route.pop_front();
				check_field("action", want.act, action);
				check_field("packet_kind", want.kind, packet_kind);
				check_field("out_destination", want.dest, out_destination);
				check_field("out_hop_count", want.hops, out_hop_count);
				act_seen[want.act]++;
				checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d decisions outstanding", $time, due_route.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		int p;
		rndr_pkg::node_id_t phase_ids [PHASES];
		for (p = 0; p < 8; p++)
			id_pool[p] = rndr_pkg::node_id_t'($urandom);
		phase_ids[0] = 8'hff;
		phase_ids[1] = 8'h00;
		phase_ids[2] = rndr_pkg::node_id_t'($urandom);
		phase_ids[3] = 8'h01;
		phase_ids[4] = rndr_pkg::node_id_t'($urandom);
		phase_ids[5] = 8'hfe;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_own_id(8'd5);

		// empty table, ring unknown
		push_req(rndr_pkg::OP_NORMAL, rndr_pkg::PORT_APP, 8'd9, 16'd0);
		push_req(rndr_pkg::OP_NORMAL, rndr_pkg::PORT_APP, 8'd5, rndr_pkg::HOP_MAX);
		push_req(rndr_pkg::OP_NORMAL, rndr_pkg::PORT_GATE0, 8'd200, rndr_pkg::HOP_MAX);
		push_req(rndr_pkg::OP_NORMAL, PORT_GATE1, 8'd0, rndr_pkg::HOP_MAX - 16'd1);
		push_req(rndr_pkg::OP_NORMAL, PORT_SPARE, 8'd255, 16'h8000);
		push_req(rndr_pkg::OP_START, rndr_pkg::PORT_APP, 8'd77, 16'h1234);
		push_req(OP_UNUSED, PORT_GATE1, 8'd5, 16'h00ff);
		// learn four foreign ids
		push_req(rndr_pkg::OP_DISCOVERY, PORT_GATE1, 8'h00, 16'd3);
		push_req(rndr_pkg::OP_DISCOVERY, PORT_GATE1, 8'hff, rndr_pkg::HOP_MAX);
		push_req(rndr_pkg::OP_DISCOVERY, rndr_pkg::PORT_GATE0, 8'h33, 16'd0);
		push_req(rndr_pkg::OP_DISCOVERY, PORT_SPARE, 8'haa, 16'h5555);
		push_req(rndr_pkg::OP_NORMAL, rndr_pkg::PORT_APP, 8'haa, 16'd10);
		// own discovery comes back, twice
		push_req(rndr_pkg::OP_DISCOVERY, PORT_GATE1, 8'd5, 16'd7);
		push_req(rndr_pkg::OP_DISCOVERY, PORT_GATE1, 8'd5, rndr_pkg::HOP_MAX);
		// lookups: table is aa 33 ff 00
		push_req(rndr_pkg::OP_NORMAL, rndr_pkg::PORT_APP, 8'haa, 16'd1);
		push_req(rndr_pkg::OP_NORMAL, rndr_pkg::PORT_APP, 8'h33, 16'd2);
		push_req(rndr_pkg::OP_NORMAL, rndr_pkg::PORT_APP, 8'hff, rndr_pkg::HOP_MAX);
		push_req(rndr_pkg::OP_NORMAL, rndr_pkg::PORT_APP, 8'h00, 16'd4);
		push_req(rndr_pkg::OP_NORMAL, rndr_pkg::PORT_APP, 8'h77, 16'd5);
		push_req(rndr_pkg::OP_NORMAL, rndr_pkg::PORT_APP, 8'd5, 16'd6);
		// duplicate id, the front copy decides
		push_req(rndr_pkg::OP_DISCOVERY, PORT_GATE1, 8'hff, 16'd8);
		push_req(rndr_pkg::OP_NORMAL, rndr_pkg::PORT_APP, 8'hff, 16'hfff0);
		push_req(rndr_pkg::OP_NORMAL, rndr_pkg::PORT_GATE0, 8'hff, 16'hfff0);
		drain();

		for (p = 0; p < PHASES; p++) begin
			write_own_id(phase_ids[p]);
			if (p == 1)
				hold_req <= 1'b1;
			if (p == 3)
				steady <= 1'b1;
			push_random(PHASE_ITEMS / 2, (p == 0) ? 2 : 10);
			if (p == 2)
				drain();
			push_random(PHASE_ITEMS / 2, (p == 0) ? 2 : 10);
			drain();
			steady <= 1'b0;
		end

		$display("%0d requests accepted, %0d decisions checked under %0d node ids",
			accepted, checked, id_settings);
		$display("absorb %0d, deliver %0d, clockwise %0d, counter-clockwise %0d, table %0d/%0d",
			act_seen[rndr_pkg::ACT_ABSORB], act_seen[rndr_pkg::ACT_DELIVER],
			act_seen[rndr_pkg::ACT_CW], act_seen[rndr_pkg::ACT_CCW],
			learned_count, rndr_pkg::MAX_NODES);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
